// ===== sv/fud_pkg.sv =====
// ----------------------------------------------------------------------------
// fud_pkg: shared types and constants of the file URI percent decoder
// Holds the prefix and host text tables, the hex digit decoder and the
// result record passed from the parser step to the output register.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned HostLen   = 9;

  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharPercent = 8'h25;

  // One parser result; valid says that the byte step produced a transaction
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       rejected;
  } res_t;

  // Characters of "file://"
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h69; // i
      3'd2:    c = 8'h6C; // l
      3'd3:    c = 8'h65; // e
      3'd4:    c = 8'h3A; // :
      3'd5:    c = 8'h2F; // /
      3'd6:    c = 8'h2F; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of "localhost"
  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6C; // l
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h63; // c
      4'd3:    c = 8'h61; // a
      4'd4:    c = 8'h6C; // l
      4'd5:    c = 8'h68; // h
      4'd6:    c = 8'h6F; // o
      4'd7:    c = 8'h73; // s
      4'd8:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: {bad, nibble}; bad is set for anything but 0-9, a-f, A-F
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b0, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b0, 4'(b - 8'h37)};
    end else begin
      r = 5'b1_0000;
    end
    return r;
  endfunction

endpackage

// ===== sv/fud_if.sv =====
// ----------------------------------------------------------------------------
// fud_if: stream channels of the file URI percent decoder
// Input channel carries raw URI bytes, output channel carries decoded
// path bytes and the final verdict. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;
  logic       rejected;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output rejected, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  input rejected, output ready);
endinterface

// ===== sv/fud_step.sv =====
// ----------------------------------------------------------------------------
// fud_step: parser state and single-byte step logic
// Holds the URI parse state and computes, for the byte in the input
// register, the next state and the result transaction it causes.
// ----------------------------------------------------------------------------
module fud_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output fud_pkg::res_t res_o
);
  import fud_pkg::*;

  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhHost   = 3'd1,
    PhPath   = 3'd2,
    PhHex1   = 3'd3,
    PhHex2   = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0] hi_q, hi_d;
  logic       hi_bad_q, hi_bad_d;
  logic       failed_q, failed_d;

  logic       emit;
  logic [7:0] obyte;
  logic [4:0] hex;
  logic       rej;

  assign hex = hex_digit(byte_i);

  // Parse step for one byte
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hi_d     = hi_q;
    hi_bad_d = hi_bad_q;
    failed_d = failed_q;
    emit     = 1'b0;
    obyte    = 8'h00;

    if (!failed_q) begin
      unique case (phase_q)
        PhPrefix: begin
          if (cnt_q < 4'(PrefixLen) && byte_i == prefix_char(cnt_q[2:0])) begin
            if (cnt_q == 4'(PrefixLen - 1)) begin
              phase_d = PhHost;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
        PhHost: begin
          if (byte_i == CharSlash) begin
            if (cnt_q == 4'd0 || cnt_q == 4'(HostLen)) begin
              phase_d = PhPath;
              emit    = 1'b1;
              obyte   = byte_i;
            end else begin
              failed_d = 1'b1;
            end
          end else if (cnt_q < 4'(HostLen) && byte_i == host_char(cnt_q)) begin
            cnt_d = cnt_q + 4'd1;
          end else begin
            failed_d = 1'b1;
          end
        end
        PhPath: begin
          if (byte_i == CharPercent) begin
            phase_d = PhHex1;
          end else begin
            emit  = 1'b1;
            obyte = byte_i;
          end
        end
        PhHex1: begin
          hi_bad_d = hex[4];
          hi_d     = hex[3:0];
          phase_d  = PhHex2;
        end
        PhHex2: begin
          // encoded zero byte and bad digits reject
          if (hi_bad_q || hex[4] || (hi_q == 4'd0 && hex[3:0] == 4'd0)) begin
            failed_d = 1'b1;
          end else begin
            emit    = 1'b1;
            obyte   = {hi_q, hex[3:0]};
            phase_d = PhPath;
          end
        end
        default: failed_d = 1'b1;
      endcase
    end
  end

  // Result of this byte
  assign rej = failed_d || (phase_d != PhPath);

  always_comb begin
    res_o = '0;
    if (last_i) begin
      res_o.valid     = 1'b1;
      res_o.out_last  = 1'b1;
      res_o.rejected  = rej;
      res_o.out_valid = !rej && emit;
      res_o.out_byte  = (!rej && emit) ? obyte : 8'h00;
    end else if (emit && !failed_d) begin
      res_o.valid     = 1'b1;
      res_o.out_valid = 1'b1;
      res_o.out_byte  = obyte;
    end
  end

  // Parse state; the final byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhPrefix;
      cnt_q    <= '0;
      hi_q     <= '0;
      hi_bad_q <= 1'b0;
      failed_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q  <= PhPrefix;
        cnt_q    <= '0;
        hi_q     <= '0;
        hi_bad_q <= 1'b0;
        failed_q <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        hi_q     <= hi_d;
        hi_bad_q <= hi_bad_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

// ===== sv/file_uri_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// file_uri_percent_decoder: streaming file URI checker and percent decoder
// Input register, one parser step, output register.
// ----------------------------------------------------------------------------
// Takes one URI byte per cycle and sustains one byte per cycle in both
// directions unless the output stalls. The rate is set by the parser
// state in fud_step, which advances by one byte per unstalled clock.
// Scheme and host bytes, percent signs and the first escape digit give
// no output transaction; every path byte does until the URI fails, and
// the final byte always does, carrying the accept/reject verdict. On a
// reject the consumer drops the path bytes already delivered for that
// URI. Backpressure on the output stalls the whole pipeline.
module file_uri_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  fud_in_if.sink    in_i,
  fud_out_if.source out_o
);
  import fud_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       adv;
  res_t       res;
  res_t       out_q;

  // Pipeline moves when the output register is free or being drained
  assign adv        = !out_q.valid || out_o.ready;
  assign in_i.ready = !s1_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.in_last;
    end
  end

  fud_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_valid_q && adv),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (adv) begin
      if (s1_valid_q) begin
        out_q <= res;
      end else begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_q.valid;
  assign out_o.out_byte  = out_q.out_byte;
  assign out_o.out_valid = out_q.out_valid;
  assign out_o.out_last  = out_q.out_last;
  assign out_o.rejected  = out_q.rejected;

endmodule

// ===== sv/fud_checker.sv =====
// ----------------------------------------------------------------------------
// fud_checker: port-level assertions for the file URI percent decoder
// Checks result consistency and output handshake rules on the top ports.
// ----------------------------------------------------------------------------
module fud_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_byte_valid_i,
  input logic       out_last_i,
  input logic       rejected_i
);

  // A rejected verdict never carries a byte
  a_rej_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> !out_byte_valid_i && out_byte_i == 8'h00)
    else $error("rejected transaction carries a path byte");

  // Only the final transaction may carry a verdict
  a_rej_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> out_last_i)
    else $error("reject flagged on a non-final transaction");

  // A non-final transaction always holds a decoded byte
  a_mid_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_byte_valid_i)
    else $error("empty non-final transaction");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i) && $stable(rejected_i))
    else $error("output transaction changed while stalled");

endmodule

bind file_uri_percent_decoder fud_checker u_fud_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_byte_i       (out_o.out_byte),
  .out_byte_valid_i (out_o.out_valid),
  .out_last_i       (out_o.out_last),
  .rejected_i       (out_o.rejected)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the file URI percent decoder
// Sends directed and random URI byte streams through the input channel,
// predicts every decoded path byte and verdict, and checks each output
// transaction in order. Both channels see random idle and stall periods.
// ----------------------------------------------------------------------------
module tb_top;
  import fud_pkg::*;

  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned BurstItems    = 350;
  localparam int unsigned TotalItems    = 1850;

  // Parser phases of the decoder
  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_AUTH   = 3'd1,
    PH_PATH   = 3'd2,
    PH_HEX_HI = 3'd3,
    PH_HEX_LO = 3'd4
  } uri_phase_e;

  // One expected output transaction
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       is_last;
    logic       rejected;
  } path_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fud_in_if  in_ch ();
  fud_out_if out_ch ();

  file_uri_percent_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  string scheme_str = "file://";
  string host_str   = "localhost";

  // Predicted decoder state
  uri_phase_e  phase_q;
  int unsigned matched;
  logic [3:0]  hi_nib;
  logic        hi_bad;
  logic        uri_failed;

  path_res_t   decoded_q [$];
  path_res_t   want;
  logic [7:0]  uri_text [$];

  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_left = 0;
  logic        ready_level = 1'b1;
  bit          pace_on = 1'b1;

  // Clock
  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!pace_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hex digit value as {bad, nibble}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b0, 4'(lc - 8'h57)};
    return 5'h10;
  endfunction

  // Hex digit text for a nibble, upper or lower case at random
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 4'd10);
  endfunction

  function automatic void clear_uri_state();
    phase_q    = PH_SCHEME;
    matched    = 0;
    hi_nib     = 4'h0;
    hi_bad     = 1'b0;
    uri_failed = 1'b0;
  endfunction

  // Append one byte to the URI under construction
  task automatic add_char(input logic [7:0] c);
    uri_text = {uri_text, c};
  endtask

  // Advance the predicted parser by one accepted byte
  task automatic decode_step(input logic [7:0] c, input logic is_last);
    logic       emit;
    logic [7:0] ob;
    logic [4:0] hex;
    logic       rej;
    path_res_t  r;
    emit = 1'b0;
    ob   = 8'h00;
    if (!uri_failed) begin
      case (phase_q)
        PH_SCHEME: begin
          if (matched < PrefixLen && c == scheme_str[matched]) begin
            matched++;
            if (matched == PrefixLen) begin
              phase_q = PH_AUTH;
              matched = 0;
            end
          end else begin
            uri_failed = 1'b1;
          end
        end
        PH_AUTH: begin
          if (c == CharSlash) begin
            // empty host or the full "localhost" only
            if (matched == 0 || matched == HostLen) begin
              phase_q = PH_PATH;
              emit    = 1'b1;
              ob      = c;
            end else begin
              uri_failed = 1'b1;
            end
          end else if (matched < HostLen && c == host_str[matched]) begin
            matched++;
          end else begin
            uri_failed = 1'b1;
          end
        end
        PH_PATH: begin
          if (c == CharPercent) begin
            phase_q = PH_HEX_HI;
          end else begin
            emit = 1'b1;
            ob   = c;
          end
        end
        PH_HEX_HI: begin
          hex     = nibble_of(c);
          hi_bad  = hex[4];
          hi_nib  = hex[3:0];
          phase_q = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          hex = nibble_of(c);
          // bad digit or an encoded zero byte
          if (hi_bad || hex[4] || (hi_nib == 4'h0 && hex[3:0] == 4'h0)) begin
            uri_failed = 1'b1;
          end else begin
            emit    = 1'b1;
            ob      = {hi_nib, hex[3:0]};
            phase_q = PH_PATH;
          end
        end
        default: uri_failed = 1'b1;
      endcase
    end

    if (is_last) begin
      rej          = uri_failed || phase_q != PH_PATH;
      r.data_valid = !rej && emit;
      r.data       = r.data_valid ? ob : 8'h00;
      r.is_last    = 1'b1;
      r.rejected   = rej;
      decoded_q    = {decoded_q, r};
      clear_uri_state();
    end else if (emit) begin
      r = '{data: ob, data_valid: 1'b1, is_last: 1'b0, rejected: 1'b0};
      decoded_q = {decoded_q, r};
    end
  endtask

  // Send one byte, wait until the input channel accepts it, then predict
  task automatic send_item(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    gap = pause_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.in_last <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    decode_step(c, is_last);
    items_sent++;
  endtask

  task automatic send_uri();
    foreach (uri_text[i]) send_item(uri_text[i], i == uri_text.size() - 1);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic send_literal(input string s);
    uri_text.delete();
    put_text(s);
    send_uri();
  endtask

  // Random URI: mostly well formed, some broken, some line noise
  task automatic build_uri();
    int unsigned kind;
    int unsigned k;
    int unsigned n;
    logic [7:0]  c;
    uri_text.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      n = $urandom_range(1, 12);
      repeat (n) add_char(8'($urandom));
      return;
    end

    // scheme, now and then broken at a random spot
    if (kind < 12) begin
      k = $urandom_range(0, PrefixLen - 1);
      for (int i = 0; i < k; i++) add_char(scheme_str[i]);
      add_char(8'($urandom));
      if ($urandom_range(0, 1)) return;
    end else begin
      put_text(scheme_str);
    end

    // authority
    k = $urandom_range(0, 99);
    if (k >= 45 && k < 88) begin
      put_text(host_str);
    end else if (k >= 88 && k < 94) begin
      n = $urandom_range(1, HostLen - 1);
      for (int i = 0; i < n; i++) add_char(host_str[i]);
    end else if (k >= 94) begin
      put_text(host_str);
      add_char(8'($urandom));
    end
    if ($urandom_range(0, 99) < 4) return;

    // path
    add_char(CharSlash);
    n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10) : $urandom_range(11, 40);
    repeat (n) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        c = 8'($urandom);
        add_char(c == CharPercent ? CharSlash : c);
      end else if (k < 88) begin
        c = 8'($urandom_range(1, 255));
        add_char(CharPercent);
        add_char(hex_char(c[7:4]));
        add_char(hex_char(c[3:0]));
      end else if (k < 94) begin
        // escape with a digit that may not be hex
        add_char(CharPercent);
        add_char($urandom_range(0, 1) ? 8'($urandom) : hex_char(4'($urandom)));
        add_char($urandom_range(0, 1) ? 8'($urandom) : hex_char(4'($urandom)));
      end else if (k < 97) begin
        put_text("%00");
      end else begin
        // ends in the middle of an escape
        add_char(CharPercent);
        if ($urandom_range(0, 1)) add_char(hex_char(4'($urandom)));
        return;
      end
    end
  endtask

  task automatic test_directed();
    pace_on = 1'b1;
    uri_text.delete();
    put_text("file:///");
    add_char(8'h00);
    add_char(8'hFF);
    send_uri();
    send_literal("file://localhost/%41%7e%Fa");
    send_literal("file:///plain");
    send_literal("x");
    send_literal("filE:///");
    send_literal("file://localhos/");
    send_literal("file://localhostt/a");
    send_literal("file://localhost");
    send_literal("file://");
    send_literal("file:///%g1");
    send_literal("file:///%1z/b");
    send_literal("file:///%00abc");
    send_literal("file:///ab%4");
    send_literal("file:///a%");
  endtask

  // Random URIs with no idling on either side
  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = items_sent + BurstItems;
    pace_on = 1'b0;
    while (items_sent < stop_at) begin
      build_uri();
      send_uri();
    end
  endtask

  // Random URIs with random gaps and output stalls
  task automatic test_paced_random();
    pace_on = 1'b1;
    while (items_sent < TotalItems) begin
      build_uri();
      send_uri();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Output ready: runs of ready and stall of random length
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      if (!pace_on) begin
        ready_level = 1'b1;
        ready_left  = 1;
      end else if ($urandom_range(0, 99) < 65) begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(1, 20);
      end else begin
        ready_level = 1'b0;
        ready_left  = pause_len() + 1;
      end
    end
    ready_left--;
    out_ch.ready <= ready_level;
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual byte %0h last %0b",
                 $time, out_ch.out_byte, out_ch.out_last);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.data, out_ch.out_byte);
        check_field("out_valid", 8'(want.data_valid), 8'(out_ch.out_valid));
        check_field("out_last", 8'(want.is_last), 8'(out_ch.out_last));
        check_field("rejected", 8'(want.rejected), 8'(out_ch.rejected));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: timeout, %0d predictions pending", $time, decoded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    clear_uri_state();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_paced_random();

    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fud_pkg.sv
sv/fud_if.sv
sv/fud_step.sv
sv/file_uri_percent_decoder.sv
sv/fud_checker.sv
tb/tb_top.sv
